// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for next-cycle implication checks, with and without a reset guard.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent in this cycle implies consequent in the next, ignored in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("glpf assertion failed");

// same, but also checked while reset is high
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("glpf assertion failed");

`endif

// File: src/glpf_pkg.sv
// ----------------------------------------------------------------------------
// glpf_pkg
// Shared sizes, codes and types of the grid local peak finder.
// ----------------------------------------------------------------------------
package glpf_pkg;

   localparam int MAX_ROWS    = 64;
   localparam int MAX_COLS    = 32;
   localparam int HEIGHT_BITS = 16;

   localparam int ROW_W   = $clog2(MAX_ROWS);
   localparam int COL_W   = $clog2(MAX_COLS);
   localparam int NROWS_W = 7;
   localparam int NCOLS_W = 6;

   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 7;
   localparam logic [CSR_ADDR_W-1:0] CSR_NUM_ROWS = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_NUM_COLS = 1'b1;

   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   typedef logic signed [HEIGHT_BITS-1:0] height_type;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             last;
   } peak_type;

   typedef struct packed {
      logic     valid;
      peak_type data;
   } push_type;

   // index of the last row after clamping the register to 1..MAX_ROWS
   function automatic logic [ROW_W-1:0] last_row_of(input logic [NROWS_W-1:0] v);
      logic [NROWS_W-1:0] t;
      if (v == '0) begin
         t = NROWS_W'(1);
      end else if (v > NROWS_W'(MAX_ROWS)) begin
         t = NROWS_W'(MAX_ROWS);
      end else begin
         t = v;
      end
      return ROW_W'(t - NROWS_W'(1));
   endfunction

   // index of the last column after clamping the register to 1..MAX_COLS
   function automatic logic [COL_W-1:0] last_col_of(input logic [NCOLS_W-1:0] v);
      logic [NCOLS_W-1:0] t;
      if (v == '0) begin
         t = NCOLS_W'(1);
      end else if (v > NCOLS_W'(MAX_COLS)) begin
         t = NCOLS_W'(MAX_COLS);
      end else begin
         t = v;
      end
      return COL_W'(t - NCOLS_W'(1));
   endfunction

endpackage

// File: src/glpf_req_if.sv
// ----------------------------------------------------------------------------
// glpf_req_if
// Request channel: one grid height per transfer.
// ----------------------------------------------------------------------------
interface glpf_req_if;
   logic                  valid;
   logic                  ready;
   glpf_pkg::height_type  height;

   modport source (output valid, output height, input ready);
   modport sink   (input valid, input height, output ready);
endinterface

// File: src/glpf_rsp_if.sv
// ----------------------------------------------------------------------------
// glpf_rsp_if
// Response channel: position of one local peak per transfer.
// ----------------------------------------------------------------------------
interface glpf_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [glpf_pkg::ROW_W-1:0]     peak_row;
   logic [glpf_pkg::COL_W-1:0]     peak_col;
   logic                           last_of_run;

   modport source (output valid, output peak_row, output peak_col, output last_of_run,
                   input ready);
   modport sink   (input valid, input peak_row, input peak_col, input last_of_run,
                   output ready);
endinterface

// File: src/glpf_front.sv
// ----------------------------------------------------------------------------
// glpf_front
// Accepts heights, keeps the two line buffers and the frame position, runs the
// peak test for the cell above each new one and the last-row sweep, and
// queues every peak found.
// ----------------------------------------------------------------------------
module glpf_front (
   input  logic                                clock,
   input  logic                                reset,
   glpf_req_if.sink                            req_chan,
   input  logic                                csr_we,
   input  logic [glpf_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [glpf_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                q_full,
   output glpf_pkg::push_type                  q_push
);

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_RD2     = 7'b0000010,
      ST_EXEC    = 7'b0000100,
      ST_SW_RD1  = 7'b0001000,
      ST_SW_RD2  = 7'b0010000,
      ST_SW_EXEC = 7'b0100000,
      ST_FLUSH   = 7'b1000000
   } state_type;

   // line buffers
   glpf_pkg::height_type prev_row_mem [glpf_pkg::MAX_COLS];
   glpf_pkg::height_type prev2_mem    [glpf_pkg::MAX_COLS];

   state_type                        state_ff, state_in;
   logic [glpf_pkg::NROWS_W-1:0]     num_rows_ff, num_rows_in;
   logic [glpf_pkg::NCOLS_W-1:0]     num_cols_ff, num_cols_in;
   logic [glpf_pkg::ROW_W-1:0]       row_cnt_ff, row_cnt_in;
   logic [glpf_pkg::COL_W-1:0]       col_cnt_ff, col_cnt_in;
   logic                             pend_valid_ff, pend_valid_in;

   logic [glpf_pkg::ROW_W-1:0]       r_ff, r_in;
   logic [glpf_pkg::COL_W-1:0]       c_ff, c_in;
   logic [glpf_pkg::ROW_W-1:0]       last_row_ff, last_row_in;
   logic [glpf_pkg::COL_W-1:0]       last_col_ff, last_col_in;
   logic [glpf_pkg::COL_W-1:0]       j_ff, j_in;
   glpf_pkg::height_type             h_ff, h_in;
   glpf_pkg::height_type             self_ff, self_in;
   glpf_pkg::height_type             up_ff, up_in;
   glpf_pkg::height_type             left_ff, left_in;
   glpf_pkg::height_type             rd_pr_ff, rd_p2_ff;
   glpf_pkg::peak_type               pend_ff, pend_in;

   logic [glpf_pkg::ROW_W-1:0]       last_row_now, r_now;
   logic [glpf_pkg::COL_W-1:0]       last_col_now, c_now;
   logic [glpf_pkg::COL_W-1:0]       pr_addr, p2_addr;
   logic                             accept, wr_en, go, found, peak;
   glpf_pkg::height_type             cmp_left;
   logic                             down_ok, up_ok, left_ok, right_ok;
   glpf_pkg::peak_type               found_entry;

   function automatic logic peak_test(
      input glpf_pkg::height_type self,
      input glpf_pkg::height_type down,
      input logic                 down_en,
      input glpf_pkg::height_type up,
      input logic                 up_en,
      input glpf_pkg::height_type left,
      input logic                 left_en,
      input glpf_pkg::height_type right,
      input logic                 right_en
   );
      logic ok;
      ok = 1'b1;
      if (down_en  && (self < down))  ok = 1'b0;
      if (up_en    && (self < up))    ok = 1'b0;
      if (left_en  && (self < left))  ok = 1'b0;
      if (right_en && (self < right)) ok = 1'b0;
      return ok;
   endfunction

   assign last_row_now = glpf_pkg::last_row_of(num_rows_ff);
   assign last_col_now = glpf_pkg::last_col_of(num_cols_ff);
   assign r_now = (row_cnt_ff > last_row_now) ? last_row_now : row_cnt_ff;
   assign c_now = (col_cnt_ff > last_col_now) ? last_col_now : col_cnt_ff;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept = req_chan.valid && req_chan.ready;

   // read addresses: the cell itself first, then its right and left neighbors
   // (in the sweep only the right one), held while the test waits on a full queue
   always_comb begin
      case (state_ff)
         ST_IDLE: begin
            pr_addr = c_now;
            p2_addr = c_now;
         end
         ST_RD2, ST_EXEC: begin
            pr_addr = c_ff + glpf_pkg::COL_W'(1);
            p2_addr = c_ff - glpf_pkg::COL_W'(1);
         end
         ST_SW_RD1: begin
            pr_addr = j_ff;
            p2_addr = j_ff;
         end
         ST_SW_RD2, ST_SW_EXEC: begin
            pr_addr = j_ff + glpf_pkg::COL_W'(1);
            p2_addr = j_ff;
         end
         default: begin
            pr_addr = c_ff;
            p2_addr = c_ff;
         end
      endcase
   end

   // neighbor selection for the step test and the sweep test
   always_comb begin
      if (state_ff == ST_SW_EXEC) begin
         down_ok  = 1'b0;
         up_ok    = (last_row_ff != '0);
         cmp_left = left_ff;
         left_ok  = (j_ff != '0);
         right_ok = (j_ff != last_col_ff);
      end else begin
         down_ok  = 1'b1;
         up_ok    = (r_ff > glpf_pkg::ROW_W'(1));
         cmp_left = rd_p2_ff;
         left_ok  = (c_ff != '0);
         right_ok = (c_ff != last_col_ff);
      end
      peak = peak_test(self_ff, h_ff, down_ok, up_ff, up_ok, cmp_left, left_ok,
                       rd_pr_ff, right_ok);
      found = ((state_ff == ST_EXEC) && (r_ff != '0) && peak) ||
              ((state_ff == ST_SW_EXEC) && peak);
      if (state_ff == ST_SW_EXEC) begin
         found_entry.row = r_ff;
         found_entry.col = j_ff;
      end else begin
         found_entry.row = r_ff - glpf_pkg::ROW_W'(1);
         found_entry.col = c_ff;
      end
      found_entry.last = 1'b0;
   end

   always_comb begin
      state_in      = state_ff;
      num_rows_in   = num_rows_ff;
      num_cols_in   = num_cols_ff;
      row_cnt_in    = row_cnt_ff;
      col_cnt_in    = col_cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      r_in          = r_ff;
      c_in          = c_ff;
      last_row_in   = last_row_ff;
      last_col_in   = last_col_ff;
      j_in          = j_ff;
      h_in          = h_ff;
      self_in       = self_ff;
      up_in         = up_ff;
      left_in       = left_ff;
      wr_en         = 1'b0;
      go            = 1'b1;
      q_push.valid  = 1'b0;
      q_push.data   = pend_ff;

      if (csr_we) begin
         case (csr_addr)
            glpf_pkg::CSR_NUM_ROWS: num_rows_in = csr_wdata[glpf_pkg::NROWS_W-1:0];
            glpf_pkg::CSR_NUM_COLS: num_cols_in = csr_wdata[glpf_pkg::NCOLS_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               h_in        = req_chan.height;
               r_in        = r_now;
               c_in        = c_now;
               last_row_in = last_row_now;
               last_col_in = last_col_now;
               state_in    = ST_RD2;
            end
         end
         ST_RD2, ST_SW_RD2: begin
            self_in  = rd_pr_ff;
            up_in    = rd_p2_ff;
            state_in = (state_ff == ST_RD2) ? ST_EXEC : ST_SW_EXEC;
         end
         ST_SW_RD1: begin
            state_in = ST_SW_RD2;
         end
         ST_EXEC, ST_SW_EXEC: begin
            // a second peak in the same run releases the held one as not last
            go = !(found && pend_valid_ff && q_full);
            if (go) begin
               if (found) begin
                  q_push.valid  = pend_valid_ff;
                  pend_valid_in = 1'b1;
                  pend_in       = found_entry;
               end
               if (state_ff == ST_EXEC) begin
                  wr_en = 1'b1;
                  if (c_ff == last_col_ff) begin
                     col_cnt_in = '0;
                     if (r_ff == last_row_ff) begin
                        row_cnt_in = '0;
                        j_in       = '0;
                        state_in   = ST_SW_RD1;
                     end else begin
                        row_cnt_in = r_ff + glpf_pkg::ROW_W'(1);
                        state_in   = ST_FLUSH;
                     end
                  end else begin
                     col_cnt_in = c_ff + glpf_pkg::COL_W'(1);
                     row_cnt_in = r_ff;
                     state_in   = ST_FLUSH;
                  end
               end else begin
                  left_in = self_ff;
                  if (j_ff == last_col_ff) begin
                     state_in = ST_FLUSH;
                  end else begin
                     j_in     = j_ff + glpf_pkg::COL_W'(1);
                     state_in = ST_SW_RD1;
                  end
               end
            end
         end
         ST_FLUSH: begin
            if (pend_valid_ff) begin
               if (!q_full) begin
                  q_push.valid       = 1'b1;
                  q_push.data.last   = 1'b1;
                  pend_valid_in      = 1'b0;
                  state_in           = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         num_rows_ff   <= glpf_pkg::NROWS_W'(1);
         num_cols_ff   <= glpf_pkg::NCOLS_W'(1);
         row_cnt_ff    <= '0;
         col_cnt_ff    <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         num_rows_ff   <= num_rows_in;
         num_cols_ff   <= num_cols_in;
         row_cnt_ff    <= row_cnt_in;
         col_cnt_ff    <= col_cnt_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      r_ff        <= r_in;
      c_ff        <= c_in;
      last_row_ff <= last_row_in;
      last_col_ff <= last_col_in;
      j_ff        <= j_in;
      h_ff        <= h_in;
      self_ff     <= self_in;
      up_ff       <= up_in;
      left_ff     <= left_in;
   end

   // line buffer ports: registered reads, one write of both buffers per step
   always_ff @(posedge clock) begin
      rd_pr_ff <= prev_row_mem[pr_addr];
      rd_p2_ff <= prev2_mem[p2_addr];
      if (wr_en) begin
         prev_row_mem[c_ff] <= h_ff;
         prev2_mem[c_ff]    <= self_ff;
      end
   end

endmodule

// File: src/glpf_fifo.sv
// ----------------------------------------------------------------------------
// glpf_fifo
// Short queue of found peaks between the front and the response stage.
// ----------------------------------------------------------------------------
module glpf_fifo (
   input  logic                clock,
   input  logic                reset,
   input  glpf_pkg::push_type  push,
   input  logic                pop,
   output glpf_pkg::peak_type  head,
   output logic                empty,
   output logic                full
);

   glpf_pkg::peak_type               entry_ff [glpf_pkg::Q_DEPTH];
   logic [glpf_pkg::Q_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [glpf_pkg::Q_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [glpf_pkg::Q_CNT_W-1:0]     count_ff, count_in;
   logic                             do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == glpf_pkg::Q_CNT_W'(glpf_pkg::Q_DEPTH));
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push.valid && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + glpf_pkg::Q_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + glpf_pkg::Q_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + glpf_pkg::Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - glpf_pkg::Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.data;
      end
   end

endmodule

// File: src/glpf_back.sv
// ----------------------------------------------------------------------------
// glpf_back
// Response stage: pulls peaks from the queue into the output register.
// ----------------------------------------------------------------------------
module glpf_back (
   input  logic                clock,
   input  logic                reset,
   input  glpf_pkg::peak_type  q_head,
   input  logic                q_empty,
   output logic                q_pop,
   glpf_rsp_if.source          rsp_chan
);

   logic                 out_valid_ff, out_valid_in;
   glpf_pkg::peak_type   out_ff, out_in;

   // refill whenever the register is empty or being drained
   assign q_pop = !q_empty && (!out_valid_ff || rsp_chan.ready);

   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (q_pop) begin
         out_in       = q_head;
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.peak_row    = out_ff.row;
   assign rsp_chan.peak_col    = out_ff.col;
   assign rsp_chan.last_of_run = out_ff.last;

endmodule

// File: src/grid_local_peak_finder_top.sv
// Each request steps through accept, neighbor read, test and buffer write, and queue push;
// the final cell of a frame adds the last-row sweep, with two reads and a test per column.
// The pace is set by the single read port of each line buffer.
// With the queue drained, each peak passes the held entry, the queue and the output
// register; on the final cell the peaks come out during the sweep, the last as it ends.
// Synchronous active-high reset clears control state and sets 1 row by 1 column;
// ----------------------------------------------------------------------------
// grid_local_peak_finder_top
// Streams grid heights in raster order and reports 4-neighbor local peaks.
// The line buffers are not cleared by reset.
// ----------------------------------------------------------------------------
module grid_local_peak_finder_top (
   input  logic                                clock,
   input  logic                                reset,
   glpf_req_if.sink                            req_chan,
   glpf_rsp_if.source                          rsp_chan,
   input  logic                                csr_we,
   input  logic [glpf_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [glpf_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   glpf_pkg::push_type   q_push;
   glpf_pkg::peak_type   q_head;
   logic                 q_full;
   logic                 q_empty;
   logic                 q_pop;

   glpf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .q_full    (q_full),
      .q_push    (q_push)
   );

   glpf_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .pop   (q_pop),
      .head  (q_head),
      .empty (q_empty),
      .full  (q_full)
   );

   glpf_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_head   (q_head),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// File: src/glpf_checker.sv
// ----------------------------------------------------------------------------
// glpf_checker
// Port-level checks of the peak finder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module glpf_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [glpf_pkg::ROW_W-1:0]     rsp_peak_row,
   input logic [glpf_pkg::COL_W-1:0]     rsp_peak_col,
   input logic                           rsp_last_of_run
);

   logic [glpf_pkg::ROW_W+glpf_pkg::COL_W:0] rsp_payload;

   assign rsp_payload = {rsp_peak_row, rsp_peak_col, rsp_last_of_run};

   // a stalled response keeps its payload
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

   // one request at a time: never ready right after a request is taken
   `ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready)

   // reset empties the response register
   `ASSERT_NEXT_ALWAYS(a_reset_rsp, clock, reset, !rsp_valid)

   // the front is waiting for a request after reset
   `ASSERT_NEXT_ALWAYS(a_reset_ready, clock, reset, req_ready)

endmodule

bind grid_local_peak_finder_top glpf_checker u_glpf_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_peak_row    (rsp_chan.peak_row),
   .rsp_peak_col    (rsp_chan.peak_col),
   .rsp_last_of_run (rsp_chan.last_of_run)
);

// File: sim/glpf_peak_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glpf_peak_checker
// Watches the request, response and register ports of the grid local peak
// finder, predicts the peak positions of every request and compares each
// response against the oldest predicted peak.
// ----------------------------------------------------------------------------
module glpf_peak_checker (
   input  logic                              clock,
   input  logic                              reset,
   glpf_req_if                               req_mon,
   glpf_rsp_if                               rsp_mon,
   input  logic                              csr_we,
   input  logic [glpf_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [glpf_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int                                mismatch_count,
   output int                                pending_peaks
);

   typedef glpf_pkg::height_type height_type;
   typedef glpf_pkg::peak_type   peak_type;

   // model copy of the two line buffers and the raster position
   height_type                     row_above   [glpf_pkg::MAX_COLS];
   height_type                     row_above2  [glpf_pkg::MAX_COLS];
   int                             next_row;
   int                             next_col;
   logic [glpf_pkg::NROWS_W-1:0]   rows_reg;
   logic [glpf_pkg::NCOLS_W-1:0]   cols_reg;
   peak_type                       expected_peaks [$];

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   function automatic void predict_peaks(input height_type h);
      int         n_rows;
      int         n_cols;
      int         r;
      int         c;
      int         j;
      height_type self;
      bit         ok;
      peak_type   p;
      peak_type   found [$];
      n_rows = int'(rows_reg);
      if (n_rows < 1) n_rows = 1;
      if (n_rows > glpf_pkg::MAX_ROWS) n_rows = glpf_pkg::MAX_ROWS;
      n_cols = int'(cols_reg);
      if (n_cols < 1) n_cols = 1;
      if (n_cols > glpf_pkg::MAX_COLS) n_cols = glpf_pkg::MAX_COLS;
      r = (next_row > n_rows - 1) ? n_rows - 1 : next_row;
      c = (next_col > n_cols - 1) ? n_cols - 1 : next_col;

      // cell one row up is tested now that its lower neighbor is known
      if (r >= 1) begin
         self = row_above[c];
         ok   = (self >= h);
         if (r >= 2 && self < row_above2[c]) ok = 0;
         if (c >= 1 && self < row_above2[c-1]) ok = 0;
         if (c + 1 < n_cols && self < row_above[c+1]) ok = 0;
         if (ok) begin
            p.row  = glpf_pkg::ROW_W'(r - 1);
            p.col  = glpf_pkg::COL_W'(c);
            p.last = 1'b0;
            found.push_back(p);
         end
      end

      row_above2[c] = row_above[c];
      row_above[c]  = h;

      if (c == n_cols - 1 && r == n_rows - 1) begin
         // final cell: sweep the bottom row, which has no lower neighbor
         for (j = 0; j < n_cols; j++) begin
            self = row_above[j];
            ok   = 1;
            if (r >= 1 && self < row_above2[j]) ok = 0;
            if (j >= 1 && self < row_above[j-1]) ok = 0;
            if (j + 1 < n_cols && self < row_above[j+1]) ok = 0;
            if (ok) begin
               p.row  = glpf_pkg::ROW_W'(r);
               p.col  = glpf_pkg::COL_W'(j);
               p.last = 1'b0;
               found.push_back(p);
            end
         end
         next_row = 0;
         next_col = 0;
      end else if (c == n_cols - 1) begin
         next_col = 0;
         next_row = r + 1;
      end else begin
         next_col = c + 1;
         next_row = r;
      end

      if (found.size() > 0) found[found.size()-1].last = 1'b1;
      foreach (found[i]) expected_peaks.push_back(found[i]);
   endfunction

   task automatic check_peak();
      peak_type want;
      if (expected_peaks.size() == 0) begin
         report_mismatch($sformatf("unexpected peak row %0d col %0d",
                                   rsp_mon.peak_row, rsp_mon.peak_col));
      end else begin
         want = expected_peaks.pop_front();
         if (rsp_mon.peak_row !== want.row)
            report_mismatch($sformatf("peak_row %0d, want %0d", rsp_mon.peak_row, want.row));
         if (rsp_mon.peak_col !== want.col)
            report_mismatch($sformatf("peak_col %0d, want %0d", rsp_mon.peak_col, want.col));
         if (rsp_mon.last_of_run !== want.last)
            report_mismatch($sformatf("last_of_run %0b, want %0b at row %0d col %0d",
                                      rsp_mon.last_of_run, want.last, want.row, want.col));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rows_reg = glpf_pkg::NROWS_W'(1);
         cols_reg = glpf_pkg::NCOLS_W'(1);
         next_row = 0;
         next_col = 0;
         expected_peaks.delete();
      end else begin
         if (csr_we) begin
            if (csr_addr == glpf_pkg::CSR_NUM_ROWS)
               rows_reg = csr_wdata[glpf_pkg::NROWS_W-1:0];
            else if (csr_addr == glpf_pkg::CSR_NUM_COLS)
               cols_reg = csr_wdata[glpf_pkg::NCOLS_W-1:0];
         end
         // predict before comparing so an answer in the same cycle as its request would still match
         if (req_mon.valid && req_mon.ready) predict_peaks(req_mon.height);
         if (rsp_mon.valid && rsp_mon.ready) check_peak();
      end
      pending_peaks <= expected_peaks.size();
   end

endmodule

// File: sim/tb_grid_local_peak_finder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_local_peak_finder_top
// Drives whole grid frames of heights through the peak finder with random
// idle cycles on both channels, resizes the grid between frames, and takes
// the verdict from the peak checker.
// ----------------------------------------------------------------------------
module tb_grid_local_peak_finder_top;

   typedef glpf_pkg::height_type height_type;

   localparam int DRAIN_CYCLES = 4 + 3 * glpf_pkg::MAX_COLS + 24;
   localparam int HOLD_CYCLES  = 300;
   localparam int RANDOM_CELLS = 370;
   localparam height_type HEIGHT_TOP    = {1'b0, {(glpf_pkg::HEIGHT_BITS-1){1'b1}}};
   localparam height_type HEIGHT_BOTTOM = {1'b1, {(glpf_pkg::HEIGHT_BITS-1){1'b0}}};

   typedef enum int {RELIEF_RANDOM, RELIEF_NARROW, RELIEF_FLAT, RELIEF_EXTREME} relief_type;

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                csr_we;
   logic [glpf_pkg::CSR_ADDR_W-1:0]     csr_addr;
   logic [glpf_pkg::CSR_DATA_W-1:0]     csr_wdata;
   int                                  mismatches;
   int                                  pending;
   int                                  cells_per_frame;
   int                                  cells_offered;
   bit                                  no_idle;
   bit                                  rsp_hold_request;

   glpf_req_if req_chan ();
   glpf_rsp_if rsp_chan ();

   grid_local_peak_finder_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   glpf_peak_checker u_peak_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatches),
      .pending_peaks  (pending)
   );

   always #10 clock = ~clock;

   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // response side: random stall per peak, plus one long hold-off on demand
   initial begin : rsp_ready_driver
      int stall;
      bit hold_done;
      rsp_chan.ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_hold_request && !hold_done) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1;
         end
         stall = no_idle ? 0 : $urandom_range(0, 5);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock);
         while (!rsp_chan.valid && !(rsp_hold_request && !hold_done));
      end
   end

   task automatic offer_height(input height_type h);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.height <= h;
      do @(posedge clock); while (!req_chan.ready);
      cells_offered++;
   endtask

   // block must be idle: every peak back and the last-row sweep finished
   task automatic drain();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic resize_grid(input int rows, input int cols);
      int n_rows;
      int n_cols;
      drain();
      csr_we    <= 1'b1;
      csr_addr  <= glpf_pkg::CSR_NUM_ROWS;
      csr_wdata <= glpf_pkg::CSR_DATA_W'(rows);
      @(posedge clock);
      csr_addr  <= glpf_pkg::CSR_NUM_COLS;
      csr_wdata <= glpf_pkg::CSR_DATA_W'(cols);
      @(posedge clock);
      csr_we    <= 1'b0;
      n_rows = (rows < 1) ? 1 : (rows > glpf_pkg::MAX_ROWS) ? glpf_pkg::MAX_ROWS : rows;
      n_cols = (cols < 1) ? 1 : (cols > glpf_pkg::MAX_COLS) ? glpf_pkg::MAX_COLS : cols;
      cells_per_frame = n_rows * n_cols;
   endtask

   task automatic send_frames(input int frames, input relief_type relief);
      height_type level;
      height_type h;
      for (int f = 0; f < frames; f++) begin
         level = height_type'($urandom);
         for (int k = 0; k < cells_per_frame; k++) begin
            case (relief)
               RELIEF_NARROW:  h = height_type'(int'($urandom_range(0, 3)) - 2);
               RELIEF_FLAT:    h = level;
               RELIEF_EXTREME: h = $urandom_range(0, 1) ? HEIGHT_TOP : HEIGHT_BOTTOM;
               default:        h = height_type'($urandom);
            endcase
            offer_height(h);
         end
      end
   endtask

   initial begin : stimulus
      int         phase;
      relief_type relief;
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_addr         = '0;
      csr_wdata        = '0;
      req_chan.valid   = 1'b0;
      req_chan.height  = '0;
      no_idle          = 0;
      rsp_hold_request = 0;
      cells_offered    = 0;
      cells_per_frame  = 1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // out of reset the grid is one cell: each request is a whole frame
      offer_height(HEIGHT_TOP);
      offer_height(HEIGHT_BOTTOM);
      // zero sizes clamp to one cell
      resize_grid(0, 0);
      offer_height(height_type'(0));
      // single row: ties and extremes side by side
      resize_grid(1, 4);
      offer_height(HEIGHT_BOTTOM);
      offer_height(HEIGHT_TOP);
      offer_height(HEIGHT_TOP);
      offer_height(height_type'(5));
      // single column
      resize_grid(4, 1);
      offer_height(height_type'(1));
      offer_height(height_type'(1));
      offer_height(HEIGHT_BOTTOM);
      offer_height(height_type'(2));
      // flat plateau: every cell is a peak
      resize_grid(2, 3);
      repeat (6) offer_height(height_type'(7));

      cells_offered = 0;
      phase = 0;
      while (cells_offered < RANDOM_CELLS) begin
         case (phase)
            1: begin
               // rows beyond range clamp to the maximum
               resize_grid(127, 1);
               no_idle = 0;
               send_frames(1, RELIEF_NARROW);
            end
            3: begin
               // widest plateau gives the longest run of peaks on one request;
               // the response side holds off while requests keep coming
               resize_grid(2, 63);
               no_idle = 1;
               rsp_hold_request = 1;
               send_frames(1, RELIEF_FLAT);
            end
            5: begin
               resize_grid(1, 32);
               no_idle = 0;
               send_frames(1, RELIEF_RANDOM);
            end
            7: begin
               resize_grid(64, 0);
               no_idle = 0;
               send_frames(1, RELIEF_EXTREME);
            end
            default: begin
               resize_grid($urandom_range(0, 6), $urandom_range(0, 7));
               no_idle = ($urandom_range(0, 4) == 0);
               relief  = relief_type'($urandom_range(0, 3));
               send_frames($urandom_range(1, 3), relief);
            end
         endcase
         phase++;
      end

      no_idle = 0;
      drain();
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
